// File: sv/bkd_pkg.sv
// Shared widths, register indexes, reset values and types for the backoff decider.
package bkd_pkg;

    localparam int KIND_W    = 2;
    localparam int RTT_W     = 31;
    localparam int CFG_W     = 16;
    localparam int PROB_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DLY_W     = RTT_W + 1;
    localparam int DIVD_W    = 32;
    localparam int DIVS_W    = RTT_W;
    localparam int PROD_W    = DIVD_W + DIVS_W;

    localparam logic [DIVD_W-1:0] BASE_UNIT = DIVD_W'(64'h7FFF_FFFF / 100);

    localparam logic [KIND_W-1:0] KIND_PLAIN_ACK = '0;

    localparam logic [CFG_W-1:0]  QTH_RESET = CFG_W'(20);
    localparam logic [CFG_W-1:0]  QMN_RESET = CFG_W'(5);
    localparam logic [PROB_W-1:0] MPP_RESET = PROB_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUE_THRESHOLD = 2'd0,
        REG_QUEUE_MIN       = 2'd1,
        REG_MAX_PROB        = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              forced;
        logic              forced_act;
        logic [DIVS_W-1:0] mult;
        logic [RTT_W-1:0]  rnd;
    } bkd_tag_t;

endpackage

// File: sv/bkd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module bkd_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bkd_pkg::DIVD_W-1:0]   in_dividend,
    input  logic [bkd_pkg::DIVS_W-1:0]   in_divisor,
    input  bkd_pkg::bkd_tag_t            in_tag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bkd_pkg::DIVD_W-1:0]   out_quotient,
    output bkd_pkg::bkd_tag_t            out_tag
);
    import bkd_pkg::*;

    localparam int NSTAGE = DIVD_W;

    logic [NSTAGE-1:0] valid_reg;
    logic [DIVS_W-1:0] rem_reg     [NSTAGE];
    logic [DIVD_W-1:0] work_reg    [NSTAGE];
    logic [DIVS_W-1:0] divisor_reg [NSTAGE];
    bkd_tag_t          tag_reg     [NSTAGE];

    logic [DIVS_W-1:0] src_rem     [NSTAGE];
    logic [DIVD_W-1:0] src_work    [NSTAGE];
    logic [DIVS_W-1:0] src_divisor [NSTAGE];
    bkd_tag_t          src_tag     [NSTAGE];
    logic [DIVS_W:0]   trial       [NSTAGE];
    logic [NSTAGE-1:0] fits;
    logic [DIVS_W-1:0] rem_next    [NSTAGE];
    logic [DIVD_W-1:0] work_next   [NSTAGE];
    logic              div_en;

    assign div_en       = !valid_reg[NSTAGE-1] || out_ready;
    assign in_ready     = div_en;
    assign out_valid    = valid_reg[NSTAGE-1];
    assign out_quotient = work_reg[NSTAGE-1];
    assign out_tag      = tag_reg[NSTAGE-1];

    always_comb begin
        src_rem[0]     = '0;
        src_work[0]    = in_dividend;
        src_divisor[0] = in_divisor;
        src_tag[0]     = in_tag;
        for (int k = 1; k < NSTAGE; k++) begin
            src_rem[k]     = rem_reg[k-1];
            src_work[k]    = work_reg[k-1];
            src_divisor[k] = divisor_reg[k-1];
            src_tag[k]     = tag_reg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < NSTAGE; k++) begin
            trial[k] = {src_rem[k], src_work[k][DIVD_W-1]};
            fits[k]  = trial[k] >= {1'b0, src_divisor[k]};
            if (fits[k]) begin
                rem_next[k] = DIVS_W'(trial[k] - {1'b0, src_divisor[k]});
            end else begin
                rem_next[k] = trial[k][DIVS_W-1:0];
            end
            work_next[k] = {src_work[k][DIVD_W-2:0], fits[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (div_en) begin
            valid_reg <= {valid_reg[NSTAGE-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (div_en) begin
            for (int k = 0; k < NSTAGE; k++) begin
                rem_reg[k]     <= rem_next[k];
                work_reg[k]    <= work_next[k];
                divisor_reg[k] <= src_divisor[k];
                tag_reg[k]     <= src_tag[k];
            end
        end
    end

endmodule

// File: sv/delay_based_backoff_decider.sv
// Top level of the delay-based backoff decider: decode, span select, divide, scale, compare.
//
//   Channel   Direction  Handshake          Payload
//   cfg       in         cfg_wr_en          cfg_index, cfg_wr_data
//   s         in         s_valid/s_ready    req_type, round trips, loss_recovery, random_value
//   m         out        m_valid/m_ready    action
//
// One transaction enters every cycle unless a stall on the result channel holds the input.
// Most of the pipeline is the 32-stage divider, one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults.
// A stall on the result channel holds the divider and fills the stages around it
// before the input channel stops accepting; nothing is dropped or repeated.
module delay_based_backoff_decider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bkd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bkd_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bkd_pkg::KIND_W-1:0]     s_req_type,
    input  logic [bkd_pkg::RTT_W-1:0]      s_round_trip,
    input  logic [bkd_pkg::RTT_W-1:0]      s_min_round_trip,
    input  logic [bkd_pkg::RTT_W-1:0]      s_max_round_trip,
    input  logic                           s_loss_recovery,
    input  logic [bkd_pkg::RTT_W-1:0]      s_random_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_action
);
    import bkd_pkg::*;

    logic [CFG_W-1:0]  qth_reg;
    logic [CFG_W-1:0]  qmn_reg;
    logic [PROB_W-1:0] mpp_reg;

    logic en1, en2, mul_en, out_en;

    logic                    v1_reg;
    logic signed [DLY_W-1:0] q1_reg, m1_reg;
    logic                    elig1_reg;
    logic [RTT_W-1:0]        rnd1_reg;
    logic signed [DLY_W-1:0] q1_next, m1_next;
    logic                    elig1_next;

    logic signed [DLY_W-1:0] qth_s, qmn_s;
    logic signed [DLY_W-1:0] rise_span, rise_mult, fall_span, fall_mult;
    logic                    q_gt_qmn, q_lt_qth, q_gt_qth, m_lt_q, elig2;
    logic                    v2_reg;
    logic [DIVD_W-1:0]       base2_reg, base2_next;
    logic [DIVS_W-1:0]       div2_reg, div2_next;
    bkd_tag_t                tag2_reg, tag2_next;

    logic                    dv_in_ready, dv_out_valid;
    logic [DIVD_W-1:0]       dv_quot;
    bkd_tag_t                dv_tag;

    logic                    vm_reg;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    bkd_tag_t                tagm_reg;

    logic                    m_valid_reg, m_action_reg, m_action_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qth_reg <= QTH_RESET;
            qmn_reg <= QMN_RESET;
            mpp_reg <= MPP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_QUEUE_THRESHOLD: begin
                    qth_reg <= cfg_wr_data;
                end
                REG_QUEUE_MIN: begin
                    qmn_reg <= cfg_wr_data;
                end
                REG_MAX_PROB: begin
                    mpp_reg <= cfg_wr_data[PROB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_en  = !m_valid_reg || m_ready;
    assign mul_en  = !vm_reg || out_en;
    assign en2     = !v2_reg || dv_in_ready;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign q1_next = DLY_W'({1'b0, s_round_trip}) - DLY_W'({1'b0, s_min_round_trip});
    assign m1_next = DLY_W'({1'b0, s_max_round_trip}) - DLY_W'({1'b0, s_min_round_trip});
    assign elig1_next = (s_req_type == KIND_PLAIN_ACK) && (s_round_trip != '0)
                        && (s_min_round_trip != '0) && (qth_reg != '0) && !s_loss_recovery;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            q1_reg    <= q1_next;
            m1_reg    <= m1_next;
            elig1_reg <= elig1_next;
            rnd1_reg  <= s_random_value;
        end
    end

    assign qth_s     = DLY_W'(qth_reg);
    assign qmn_s     = DLY_W'(qmn_reg);
    assign rise_span = qth_s - qmn_s;
    assign rise_mult = q1_reg - qmn_s;
    assign fall_span = m1_reg - qth_s;
    assign fall_mult = m1_reg - q1_reg;
    assign q_gt_qmn  = q1_reg > qmn_s;
    assign q_lt_qth  = q1_reg < qth_s;
    assign q_gt_qth  = q1_reg > qth_s;
    assign m_lt_q    = m1_reg < q1_reg;
    assign elig2     = elig1_reg && q_gt_qmn;

    // An ineligible transaction passes and the delay-beyond-maximum case decides a backoff, both without a division.
    always_comb begin
        tag2_next.forced     = !elig2 || (q_gt_qth && m_lt_q);
        tag2_next.forced_act = elig2;
        tag2_next.rnd        = rnd1_reg;
        if (q_lt_qth) begin
            div2_next      = rise_span[DIVS_W-1:0];
            tag2_next.mult = rise_mult[DIVS_W-1:0];
        end else if (q_gt_qth) begin
            div2_next      = fall_span[DIVS_W-1:0];
            tag2_next.mult = fall_mult[DIVS_W-1:0];
        end else begin
            div2_next      = DIVS_W'(1);
            tag2_next.mult = DIVS_W'(1);
        end
        if (tag2_next.forced) begin
            div2_next = DIVS_W'(1);
        end
    end

    assign base2_next = DIVD_W'(DIVD_W'(mpp_reg) * BASE_UNIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            base2_reg <= base2_next;
            div2_reg  <= div2_next;
            tag2_reg  <= tag2_next;
        end
    end

    bkd_divider u_divider (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (v2_reg),
        .in_ready     (dv_in_ready),
        .in_dividend  (base2_reg),
        .in_divisor   (div2_reg),
        .in_tag       (tag2_reg),
        .out_valid    (dv_out_valid),
        .out_ready    (mul_en),
        .out_quotient (dv_quot),
        .out_tag      (dv_tag)
    );

    assign prod_next = PROD_W'(dv_quot) * PROD_W'(dv_tag.mult);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (mul_en) begin
            vm_reg <= dv_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
            tagm_reg <= dv_tag;
        end
    end

    always_comb begin
        if (tagm_reg.forced) begin
            m_action_next = tagm_reg.forced_act;
        end else begin
            m_action_next = (prod_reg[PROD_W-1:RTT_W] != '0)
                            || (tagm_reg.rnd < prod_reg[RTT_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_action_reg <= m_action_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_action = m_action_reg;

`ifndef NO_ASSERTIONS
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !tag2_reg.forced |-> div2_reg != '0)
        else $error("Divider would receive a zero divisor.");

    a_scale_within_span: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !tag2_reg.forced |-> tag2_reg.mult <= div2_reg)
        else $error("Probability scale factor exceeds its span.");

    a_ineligible_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !elig1_reg && en2 |=> tag2_reg.forced && !tag2_reg.forced_act)
        else $error("Ineligible transaction was not forced to pass.");

    a_reset_clears_valids: assert property (@(posedge aclk)
        !aresetn |=> !v1_reg && !v2_reg && !vm_reg && !m_valid_reg)
        else $error("Pipeline valid bits not cleared by reset.");
`endif

endmodule
